// ===== rtl/ascii_decimal_frame_parser_assert.svh =====
// Assertion macros shared by the parser RTL.
`ifndef ASCII_DECIMAL_FRAME_PARSER_ASSERT_SVH
`define ASCII_DECIMAL_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adfp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ADFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adfp next-cycle check failed");

`endif

// ===== rtl/adfp_pkg.sv =====
`default_nettype none
package adfp_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int PTR_W = $clog2(BUFFER_DEPTH + 1);

  // Only frame positions 1 to 16 are ever decoded.
  localparam int FRAME_BYTES = 16;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_START = 8'h73;
  localparam logic [7:0] CH_DECODE = 8'h61;
  localparam logic [7:0] DIGIT_BIAS = 8'd48;

  localparam int REF_W = 16;
  localparam int POS_W = 22;

  typedef logic [PTR_W-1:0] ptr_t;

  // Entry 0 holds frame position 1.
  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    logic [REF_W-1:0] first_reference;
    logic [REF_W-1:0] second_reference;
    logic [REF_W-1:0] interval_value;
    logic [POS_W-1:0] position_value;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/adfp_frame_store.sv =====
`default_nettype none
module adfp_frame_store (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [7:0]      ch,
  output adfp_pkg::frame_t     frame
);

  adfp_pkg::ptr_t write_pointer;
  adfp_pkg::ptr_t ptr_eff;
  logic           has_room;

  always_comb begin
    ptr_eff = (ch == adfp_pkg::CH_START) ? '0 : write_pointer;
    has_room = ptr_eff < adfp_pkg::PTR_W'(adfp_pkg::BUFFER_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      frame <= '0;
    end else if (wr_en) begin
      if (has_room) begin
        write_pointer <= ptr_eff + adfp_pkg::PTR_W'(1);
        for (int j = 0; j < adfp_pkg::FRAME_BYTES; j++) begin
          if (ptr_eff == adfp_pkg::PTR_W'(j + 1)) begin
            frame[j] <= ch;
          end
        end
      end else begin
        write_pointer <= ptr_eff;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/adfp_decode.sv =====
`default_nettype none
module adfp_decode (
  input  wire adfp_pkg::frame_t  frame,
  output adfp_pkg::result_t      result
);

  localparam int W = adfp_pkg::POS_W;

  logic [adfp_pkg::FRAME_BYTES-1:0][7:0] digit;
  logic [W-1:0] first_sum;
  logic [W-1:0] second_sum;
  logic [W-1:0] interval_sum;
  logic [W-1:0] position_sum;

  function automatic logic [W-1:0] weigh(input logic [7:0] d, input int unsigned scale);
    return W'(d) * W'(scale);
  endfunction

  always_comb begin
    for (int k = 0; k < adfp_pkg::FRAME_BYTES; k++) begin
      digit[k] = frame[k] - adfp_pkg::DIGIT_BIAS;
    end
    // The three-digit references carry their extra factor of 100 in the weights.
    first_sum = weigh(digit[0], 10000) + weigh(digit[1], 1000) + weigh(digit[2], 100);
    second_sum = weigh(digit[3], 10000) + weigh(digit[4], 1000) + weigh(digit[5], 100);
    interval_sum = weigh(digit[6], 10000) + weigh(digit[7], 1000)
                 + weigh(digit[8], 100) + weigh(digit[9], 10) + W'(digit[10]);
    position_sum = weigh(digit[11], 10000) + weigh(digit[12], 1000)
                 + weigh(digit[13], 100) + weigh(digit[14], 10) + W'(digit[15]);
    result.first_reference = first_sum[adfp_pkg::REF_W-1:0];
    result.second_reference = second_sum[adfp_pkg::REF_W-1:0];
    result.interval_value = interval_sum[adfp_pkg::REF_W-1:0];
    result.position_value = position_sum;
  end

endmodule
`default_nettype wire

// ===== rtl/ascii_decimal_frame_parser.sv =====
// A decode byte is held in the input register and then sets out_valid in the result register.
// Throughput: one byte per cycle; the input register, frame store and result register
// all advance together, and only a decode byte waits for a stalled result register.
// Reset clears the write pointer, the stored frame bytes to zero and both valid flags.
`default_nettype none
`include "ascii_decimal_frame_parser_assert.svh"
module ascii_decimal_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      first_reference,
  output logic [15:0]      second_reference,
  output logic [15:0]      interval_value,
  output logic [21:0]      position_value
);

  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic              stage_is_a;
  logic              proceed;
  logic              advance;
  logic [7:0]        store_ch;
  adfp_pkg::frame_t  frame;
  adfp_pkg::result_t decoded;

  always_comb begin
    stage_is_a = stage_byte == adfp_pkg::CH_DECODE;
    proceed = !stage_is_a || !out_valid || !out_stall;
    advance = stage_valid && proceed;
    in_stall = stage_valid && !proceed;
    store_ch = (stage_byte == adfp_pkg::CH_SPACE) ? adfp_pkg::CH_ZERO : stage_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_byte <= rx_byte;
    end
  end

  adfp_frame_store u_store (
    .clk   (clk),
    .rst   (rst),
    .wr_en (advance),
    .ch    (store_ch),
    .frame (frame)
  );

  adfp_decode u_decode (
    .frame  (frame),
    .result (decoded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage_is_a) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_is_a) begin
      first_reference <= decoded.first_reference;
      second_reference <= decoded.second_reference;
      interval_value <= decoded.interval_value;
      position_value <= decoded.position_value;
    end
  end

  `ADFP_ASSERT_NEXT(a_gives_result, advance && stage_is_a, out_valid)
  `ADFP_ASSERT_NOW(plain_byte_never_stalls, stage_valid && !stage_is_a, !in_stall)
  `ADFP_ASSERT_NOW(result_from_decode_byte, $rose(out_valid), $past(advance && stage_is_a))

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 470;
  localparam int PHASE_ITEMS = 125;

  typedef struct {
    logic [7:0]        ch;
    bit                typed;
    adfp_pkg::result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] first_reference;
  logic [15:0] second_reference;
  logic [15:0] interval_value;
  logic [21:0] position_value;

  logic [7:0]        frame_mem [adfp_pkg::BUFFER_DEPTH];
  int unsigned       fill_ptr;
  adfp_pkg::result_t pending_decodes [$];
  directed_row_t     directed_rows [$];

  int errors = 0;
  int item_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  ascii_decimal_frame_parser DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .rx_byte          (rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .first_reference  (first_reference),
    .second_reference (second_reference),
    .interval_value   (interval_value),
    .position_value   (position_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned frame_digit(int pos);
    logic [7:0] d;
    d = frame_mem[pos] - adfp_pkg::DIGIT_BIAS;
    return 32'(d);
  endfunction

  task automatic absorb_byte(input logic [7:0] raw, output bit decoded,
                             output adfp_pkg::result_t res);
    logic [7:0]  ch;
    int unsigned ref_a;
    int unsigned ref_b;
    int unsigned span_a;
    int unsigned span_b;
    ch = (raw == adfp_pkg::CH_SPACE) ? adfp_pkg::CH_ZERO : raw;
    decoded = 1'b0;
    res = '0;
    if (ch == adfp_pkg::CH_START) begin
      fill_ptr = 0;
    end
    if (ch == adfp_pkg::CH_DECODE) begin
      ref_a = frame_digit(1) * 100 + frame_digit(2) * 10 + frame_digit(3);
      ref_b = frame_digit(4) * 100 + frame_digit(5) * 10 + frame_digit(6);
      span_a = frame_digit(7) * 10000 + frame_digit(8) * 1000 + frame_digit(9) * 100
             + frame_digit(10) * 10 + frame_digit(11);
      span_b = frame_digit(12) * 10000 + frame_digit(13) * 1000 + frame_digit(14) * 100
             + frame_digit(15) * 10 + frame_digit(16);
      res.first_reference = 16'(ref_a * 100);
      res.second_reference = 16'(ref_b * 100);
      res.interval_value = 16'(span_a);
      res.position_value = 22'(span_b);
      decoded = 1'b1;
    end
    if (fill_ptr < adfp_pkg::BUFFER_DEPTH) begin
      frame_mem[fill_ptr] = ch;
      fill_ptr++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input adfp_pkg::result_t want = '0);
    bit                hit;
    adfp_pkg::result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    absorb_byte(b, hit, got);
    if (hit) begin
      pending_decodes.push_back(typed ? want : got);
    end
    item_count++;
  endtask

  function automatic void add_row(logic [7:0] ch, bit typed = 1'b0, logic [15:0] f = '0,
                                  logic [15:0] s = '0, logic [15:0] iv = '0,
                                  logic [21:0] p = '0);
    directed_row_t row;
    row.ch = ch;
    row.typed = typed;
    row.want.first_reference = f;
    row.want.second_reference = s;
    row.want.interval_value = iv;
    row.want.position_value = p;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [7:0] frame_char();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) begin
      return adfp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    end else if (pick < 17) begin
      return adfp_pkg::CH_SPACE;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic check_result();
    adfp_pkg::result_t want;
    if (pending_decodes.size() == 0) begin
      $error("unexpected result: first_reference %0d", first_reference);
      errors++;
    end else begin
      want = pending_decodes.pop_front();
      if (first_reference !== want.first_reference) begin
        $error("first_reference: expected %0d, actual %0d", want.first_reference,
               first_reference);
        errors++;
      end
      if (second_reference !== want.second_reference) begin
        $error("second_reference: expected %0d, actual %0d", want.second_reference,
               second_reference);
        errors++;
      end
      if (interval_value !== want.interval_value) begin
        $error("interval_value: expected %0d, actual %0d", want.interval_value,
               interval_value);
        errors++;
      end
      if (position_value !== want.position_value) begin
        $error("position_value: expected %0d, actual %0d", want.position_value,
               position_value);
        errors++;
      end
    end
  endtask

  // The receiver checks each accepted result, then picks its stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_result();
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    string frame_text;
    int    random_start;
    int    random_items;
    int    phase;
    int    kind;
    bit    hold_done;
    logic [7:0] ch;

    for (int i = 0; i < adfp_pkg::BUFFER_DEPTH; i++) begin
      frame_mem[i] = 8'h00;
    end
    fill_ptr = 0;
    hold_done = 1'b0;

    // Unwritten positions read as zero, which decodes as digit 208.
    add_row(adfp_pkg::CH_DECODE, 1'b1, 16'd15040, 16'd15040, 16'd17328, 22'd2311088);
    add_row(adfp_pkg::CH_START);
    frame_text = "999   9999999999";
    for (int i = 0; i < frame_text.len(); i++) begin
      add_row(8'(frame_text[i]));
    end
    add_row(adfp_pkg::CH_DECODE, 1'b1, 16'd34364, 16'd0, 16'd34463, 22'd99999);
    add_row(8'hFF);
    add_row(8'h00);
    add_row(adfp_pkg::CH_START);
    add_row(8'hFF);
    add_row(adfp_pkg::CH_SPACE);
    add_row(adfp_pkg::CH_DECODE);
    add_row(adfp_pkg::CH_DECODE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);
    end

    random_start = item_count;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase = random_items / PHASE_ITEMS;
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 46;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 46;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      if (phase == 0 && random_items >= 40 && !hold_done) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_byte(adfp_pkg::CH_START);
        repeat (16 + $urandom_range(0, 3)) send_byte(frame_char());
        send_byte(adfp_pkg::CH_DECODE);
      end else if (kind == 7) begin
        // Run past the end of the buffer so the pointer saturates.
        send_byte(adfp_pkg::CH_START);
        repeat (adfp_pkg::BUFFER_DEPTH + $urandom_range(1, 12)) begin
          ch = frame_char();
          send_byte(ch == adfp_pkg::CH_START ? 8'hFF : ch);
        end
        send_byte(adfp_pkg::CH_DECODE);
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      random_items = item_count - random_start;
    end
    in_valid <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_decodes.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
